@@ rtl/msb_pkg.sv @@
// shared types, codes and widths of the multi-stack bank
package msb_pkg;

	localparam int NUM_STACKS_DEF = 8;
	localparam int POOL_NODES_DEF = 64;

	localparam int REQ_W      = 2;
	localparam int IDX_W      = 8;
	localparam int VAL_W      = 32;
	localparam int STATUS_W   = 3;
	localparam int IN_DATA_W  = 40;
	localparam int OUT_DATA_W = 32;

	localparam int QUEUE_DEPTH = 2;

	localparam logic [REQ_W-1:0] REQ_PUSH = 2'd0;
	localparam logic [REQ_W-1:0] REQ_POP  = 2'd1;
	localparam logic [REQ_W-1:0] REQ_DUMP = 2'd2;

	localparam logic [STATUS_W-1:0] ST_OK         = 3'd0;
	localparam logic [STATUS_W-1:0] ST_POP_EMPTY  = 3'd1;
	localparam logic [STATUS_W-1:0] ST_FULL       = 3'd2;
	localparam logic [STATUS_W-1:0] ST_BAD_INDEX  = 3'd3;
	localparam logic [STATUS_W-1:0] ST_IGNORED    = 3'd4;
	localparam logic [STATUS_W-1:0] ST_DUMP_EMPTY = 3'd5;

	typedef enum logic [2:0] {
		K_PUSH,
		K_POP,
		K_DUMP,
		K_IGNORE,
		K_BAD
	} cmd_kind_t;

	typedef struct packed {
		cmd_kind_t         kind;
		logic [IDX_W-1:0]  idx;
		logic [VAL_W-1:0]  value;
	} cmd_t;

endpackage

@@ rtl/msb_ram.sv @@
// generic single write port, single registered read port memory
module msb_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64,
	parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_q <= mem[raddr];
	end

	assign rdata = rdata_q;

endmodule

@@ rtl/msb_front.sv @@
// request intake: accepts stream transfers and classifies them into commands
module msb_front #(
	parameter int NUM_STACKS = msb_pkg::NUM_STACKS_DEF
) (
	input  logic                          s_axis_tvalid,
	output logic                          s_axis_tready,
	input  logic [msb_pkg::IN_DATA_W-1:0] s_axis_tdata,
	input  logic [msb_pkg::REQ_W-1:0]     s_axis_tuser,
	input  logic                          q_full,
	output logic                          q_push,
	output msb_pkg::cmd_t                 q_cmd
);

	import msb_pkg::*;

	logic [IDX_W-1:0] idx;
	logic             bad_idx;

	assign idx     = s_axis_tdata[IDX_W-1:0];
	assign bad_idx = {1'b0, idx} >= (IDX_W+1)'(NUM_STACKS);

	assign s_axis_tready = !q_full;
	assign q_push        = s_axis_tvalid && !q_full;

	always_comb begin
		q_cmd.idx   = idx;
		q_cmd.value = s_axis_tdata[IDX_W +: VAL_W];
		case (s_axis_tuser)
			REQ_PUSH: q_cmd.kind = bad_idx ? K_BAD : K_PUSH;
			REQ_POP:  q_cmd.kind = bad_idx ? K_BAD : K_POP;
			REQ_DUMP: q_cmd.kind = bad_idx ? K_BAD : K_DUMP;
			default:  q_cmd.kind = K_IGNORE;
		endcase
	end

endmodule

@@ rtl/msb_queue.sv @@
// short command queue between intake and execution
module msb_queue (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  msb_pkg::cmd_t push_cmd,
	output logic          full,
	input  logic          pop,
	output logic          head_valid,
	output msb_pkg::cmd_t head_cmd
);

	import msb_pkg::*;

	localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

	cmd_t             ent_q [QUEUE_DEPTH];
	logic [PTR_W-1:0] wr_q;
	logic [PTR_W-1:0] rd_q;
	logic [CNT_W-1:0] cnt_q;
	logic             do_pop;

	assign full       = cnt_q == CNT_W'(QUEUE_DEPTH);
	assign head_valid = cnt_q != '0;
	assign head_cmd   = ent_q[rd_q];
	assign do_pop     = pop && head_valid;

	always_ff @(posedge clk) begin
		if (push) begin
			ent_q[wr_q] <= push_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_q <= (wr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_q + PTR_W'(1);
			end
			if (do_pop) begin
				rd_q <= (rd_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_q + PTR_W'(1);
			end
			if (push && !do_pop) begin
				cnt_q <= cnt_q + CNT_W'(1);
			end else if (do_pop && !push) begin
				cnt_q <= cnt_q - CNT_W'(1);
			end
		end
	end

endmodule

@@ rtl/msb_back.sv @@
// command execution: stack heads, node pool, free list and result register
module msb_back #(
	parameter int NUM_STACKS = msb_pkg::NUM_STACKS_DEF,
	parameter int POOL_NODES = msb_pkg::POOL_NODES_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cmd_valid,
	input  msb_pkg::cmd_t                  cmd,
	output logic                           cmd_pop,
	output logic                           m_axis_tvalid,
	input  logic                           m_axis_tready,
	output logic [msb_pkg::OUT_DATA_W-1:0] m_axis_tdata,
	output logic [msb_pkg::STATUS_W-1:0]   m_axis_tuser,
	output logic                           m_axis_tlast
);

	import msb_pkg::*;

	localparam int LINK_W = $clog2(POOL_NODES + 1);
	localparam int NODE_W = $clog2(POOL_NODES);
	localparam int STK_W  = (NUM_STACKS > 1) ? $clog2(NUM_STACKS) : 1;
	localparam int KW     = $clog2(POOL_NODES);
	localparam logic [LINK_W-1:0] NULL_LINK = LINK_W'(POOL_NODES);
	localparam logic [KW-1:0]     K_MAX     = KW'(POOL_NODES - 1);

	localparam logic [1:0] S_IDLE = 2'd0;
	localparam logic [1:0] S_EXEC = 2'd1;
	localparam logic [1:0] S_POP  = 2'd2;
	localparam logic [1:0] S_WALK = 2'd3;

	logic [1:0]            state_q, state_d;
	logic [LINK_W-1:0]     free_q, free_d;
	logic [LINK_W-1:0]     fresh_q, fresh_d;
	logic [LINK_W-1:0]     cur_q, cur_d;
	logic [KW-1:0]         k_q, k_d;
	logic [NUM_STACKS-1:0] top_vld_q;

	logic                  out_vld_q;
	logic [VAL_W-1:0]      out_val_q;
	logic [STATUS_W-1:0]   out_st_q;
	logic                  out_last_q;

	logic [STK_W-1:0]        stk;
	logic [LINK_W-1:0]       top_rd;
	logic [LINK_W-1:0]       top_eff;
	logic                    top_we;
	logic [LINK_W-1:0]       top_wdata;
	logic [VAL_W+LINK_W-1:0] node_rd;
	logic [VAL_W-1:0]        rd_val;
	logic [LINK_W-1:0]       rd_next;
	logic                    node_we;
	logic [NODE_W-1:0]       node_waddr;
	logic [VAL_W+LINK_W-1:0] node_wdata;
	logic [NODE_W-1:0]       node_raddr;
	logic [LINK_W-1:0]       new_node;

	logic                    out_free;
	logic                    emit;
	logic [VAL_W-1:0]        e_val;
	logic [STATUS_W-1:0]     e_st;
	logic                    e_last;

	assign stk      = cmd.idx[STK_W-1:0];
	assign top_eff  = top_vld_q[stk] ? top_rd : NULL_LINK;
	assign rd_val   = node_rd[LINK_W +: VAL_W];
	assign rd_next  = node_rd[LINK_W-1:0];
	assign out_free = !out_vld_q || m_axis_tready;

	msb_ram #(
		.WIDTH (LINK_W),
		.DEPTH (NUM_STACKS)
	) u_top_ram (
		.clk   (clk),
		.we    (top_we),
		.waddr (stk),
		.wdata (top_wdata),
		.raddr (stk),
		.rdata (top_rd)
	);

	msb_ram #(
		.WIDTH (VAL_W + LINK_W),
		.DEPTH (POOL_NODES)
	) u_node_ram (
		.clk   (clk),
		.we    (node_we),
		.waddr (node_waddr),
		.wdata (node_wdata),
		.raddr (node_raddr),
		.rdata (node_rd)
	);

	always_comb begin
		state_d    = state_q;
		free_d     = free_q;
		fresh_d    = fresh_q;
		cur_d      = cur_q;
		k_d        = k_q;
		cmd_pop    = 1'b0;
		emit       = 1'b0;
		e_val      = '0;
		e_st       = ST_OK;
		e_last     = 1'b1;
		top_we     = 1'b0;
		top_wdata  = top_eff;
		node_we    = 1'b0;
		node_waddr = cur_q[NODE_W-1:0];
		node_wdata = {cmd.value, top_eff};
		node_raddr = free_q[NODE_W-1:0];
		new_node   = free_q;
		case (state_q)
			S_IDLE: begin
				if (cmd_valid && out_free) begin
					case (cmd.kind)
						K_IGNORE: begin
							emit    = 1'b1;
							e_st    = ST_IGNORED;
							cmd_pop = 1'b1;
						end
						K_BAD: begin
							emit    = 1'b1;
							e_st    = ST_BAD_INDEX;
							cmd_pop = 1'b1;
						end
						default: state_d = S_EXEC;
					endcase
				end
			end
			S_EXEC: begin
				case (cmd.kind)
					K_PUSH: begin
						emit    = 1'b1;
						cmd_pop = 1'b1;
						state_d = S_IDLE;
						if (free_q != NULL_LINK) begin
							new_node = free_q;
							free_d   = rd_next;
						end else if (fresh_q != NULL_LINK) begin
							new_node = fresh_q;
							fresh_d  = fresh_q + LINK_W'(1);
						end else begin
							e_st = ST_FULL;
						end
						if (e_st == ST_OK) begin
							node_we    = 1'b1;
							node_waddr = new_node[NODE_W-1:0];
							node_wdata = {cmd.value, top_eff};
							top_we     = 1'b1;
							top_wdata  = new_node;
						end
					end
					K_POP: begin
						if (top_eff == NULL_LINK) begin
							emit    = 1'b1;
							e_st    = ST_POP_EMPTY;
							cmd_pop = 1'b1;
							state_d = S_IDLE;
						end else begin
							node_raddr = top_eff[NODE_W-1:0];
							cur_d      = top_eff;
							state_d    = S_POP;
						end
					end
					default: begin
						if (top_eff == NULL_LINK) begin
							emit    = 1'b1;
							e_st    = ST_DUMP_EMPTY;
							cmd_pop = 1'b1;
							state_d = S_IDLE;
						end else begin
							node_raddr = top_eff[NODE_W-1:0];
							cur_d      = top_eff;
							k_d        = '0;
							state_d    = S_WALK;
						end
					end
				endcase
			end
			S_POP: begin
				top_we     = 1'b1;
				top_wdata  = rd_next;
				node_we    = 1'b1;
				node_waddr = cur_q[NODE_W-1:0];
				node_wdata = {rd_val, free_q};
				free_d     = cur_q;
				emit       = 1'b1;
				cmd_pop    = 1'b1;
				state_d    = S_IDLE;
			end
			S_WALK: begin
				node_raddr = cur_q[NODE_W-1:0];
				if (out_free) begin
					emit   = 1'b1;
					e_val  = rd_val;
					e_last = (rd_next == NULL_LINK) || (k_q == K_MAX);
					if (e_last) begin
						cmd_pop = 1'b1;
						state_d = S_IDLE;
					end else begin
						cur_d      = rd_next;
						k_d        = k_q + KW'(1);
						node_raddr = rd_next[NODE_W-1:0];
					end
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			free_q    <= NULL_LINK;
			fresh_q   <= '0;
			cur_q     <= NULL_LINK;
			k_q       <= '0;
			top_vld_q <= '0;
			out_vld_q <= 1'b0;
		end else begin
			state_q <= state_d;
			free_q  <= free_d;
			fresh_q <= fresh_d;
			cur_q   <= cur_d;
			k_q     <= k_d;
			if (top_we) begin
				top_vld_q[stk] <= 1'b1;
			end
			if (emit) begin
				out_vld_q <= 1'b1;
			end else if (m_axis_tready) begin
				out_vld_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			out_val_q  <= e_val;
			out_st_q   <= e_st;
			out_last_q <= e_last;
		end
	end

	assign m_axis_tvalid = out_vld_q;
	assign m_axis_tdata  = out_val_q;
	assign m_axis_tuser  = out_st_q;
	assign m_axis_tlast  = out_last_q;

	a_free_range: assert property (@(posedge clk) disable iff (!arst_n)
		free_q <= NULL_LINK)
		else $error("free list head out of range");

	a_fresh_range: assert property (@(posedge clk) disable iff (!arst_n)
		fresh_q <= NULL_LINK)
		else $error("fresh counter out of range");

	a_busy_has_cmd: assert property (@(posedge clk) disable iff (!arst_n)
		state_q != S_IDLE |-> cmd_valid)
		else $error("command lost while busy");

	a_exec_out_empty: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_EXEC || state_q == S_POP |-> !out_vld_q)
		else $error("result register occupied during execution");

	a_pop_node: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_POP || state_q == S_WALK |-> cur_q != NULL_LINK)
		else $error("walk on null node");

endmodule

@@ rtl/multi_stack_bank.sv @@
// multi-stack bank top level: request intake, command queue, execution unit
// a request is written into the command queue on its transfer and reaches the queue head behind earlier ones
// from the queue head: ignored or bad index answered in idle; push, empty pop or empty dump in exec; pop in pop
// a dump reads its top node in exec, then in walk gives one result per cycle while the output is not stalled
// the dump result rate is bounded by the single read port of the node memory
// reset empties every stack through per-stack valid bits, with no clearing pass
module multi_stack_bank #(
	parameter int NUM_STACKS = msb_pkg::NUM_STACKS_DEF,
	parameter int POOL_NODES = msb_pkg::POOL_NODES_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           s_axis_tvalid,
	output logic                           s_axis_tready,
	input  logic [msb_pkg::IN_DATA_W-1:0]  s_axis_tdata,  // stack_index, push_value
	input  logic [msb_pkg::REQ_W-1:0]      s_axis_tuser,  // req_type
	output logic                           m_axis_tvalid,
	input  logic                           m_axis_tready,
	output logic [msb_pkg::OUT_DATA_W-1:0] m_axis_tdata,  // out_value
	output logic [msb_pkg::STATUS_W-1:0]   m_axis_tuser,  // status
	output logic                           m_axis_tlast
);

	import msb_pkg::*;

	logic q_full;
	logic q_push;
	cmd_t q_cmd;
	logic q_pop;
	logic head_valid;
	cmd_t head_cmd;

	msb_front #(
		.NUM_STACKS (NUM_STACKS)
	) u_front (
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.q_full        (q_full),
		.q_push        (q_push),
		.q_cmd         (q_cmd)
	);

	msb_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (q_push),
		.push_cmd   (q_cmd),
		.full       (q_full),
		.pop        (q_pop),
		.head_valid (head_valid),
		.head_cmd   (head_cmd)
	);

	msb_back #(
		.NUM_STACKS (NUM_STACKS),
		.POOL_NODES (POOL_NODES)
	) u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd_valid     (head_valid),
		.cmd           (head_cmd),
		.cmd_pop       (q_pop),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.m_axis_tlast  (m_axis_tlast)
	);

endmodule

@@ dv/tb_multi_stack_bank.sv @@
// testbench for the multi-stack bank: directed table, then random requests checked by a predictor
`timescale 1ns / 100ps

module tb_multi_stack_bank;
	import msb_pkg::*;

	localparam int NUM_STACKS = NUM_STACKS_DEF;
	localparam int POOL_NODES = POOL_NODES_DEF;
	localparam logic [6:0] NIL = 7'(POOL_NODES);
	localparam logic [REQ_W-1:0] REQ_OTHER = 2'd3;
	localparam int STALL_LIMIT = 3000;
	localparam int DRAIN_CYCLES = 40;
	localparam int N_ROWS = 23;

	localparam int MIX_BALANCED = 0;
	localparam int MIX_FILL = 1;
	localparam int MIX_DRAIN = 2;

	typedef struct {
		logic [VAL_W-1:0]    value;
		logic [STATUS_W-1:0] status;
		logic                last;
	} result_t;

	typedef struct packed {
		logic [REQ_W-1:0]    req;
		logic [IDX_W-1:0]    idx;
		logic [VAL_W-1:0]    val;
		logic                typed;
		logic [STATUS_W-1:0] status;
	} stim_row_t;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  s_axis_tvalid = 1'b0;
	logic                  s_axis_tready;
	logic [IN_DATA_W-1:0]  s_axis_tdata = '0;
	logic [REQ_W-1:0]      s_axis_tuser = '0;
	logic                  m_axis_tvalid;
	logic                  m_axis_tready = 1'b0;
	logic [OUT_DATA_W-1:0] m_axis_tdata;
	logic [STATUS_W-1:0]   m_axis_tuser;
	logic                  m_axis_tlast;

	// predictor state
	logic [6:0]       stack_top [NUM_STACKS];
	logic [VAL_W-1:0] node_value [POOL_NODES];
	logic [6:0]       node_next [POOL_NODES];
	logic [6:0]       free_list_head;
	logic [6:0]       fresh_nodes;
	int               pool_full_hits;

	result_t queued_results [$];
	int      errors;
	int      send_idle;
	int      recv_idle;
	int      quiet_cycles;

	stim_row_t directed_rows [N_ROWS] = '{
		'{REQ_POP,   8'd0,   32'h0000_0000, 1'b1, ST_POP_EMPTY},
		'{REQ_DUMP,  8'd7,   32'h0000_0000, 1'b1, ST_DUMP_EMPTY},
		'{REQ_OTHER, 8'd255, 32'hFFFF_FFFF, 1'b1, ST_IGNORED},
		'{REQ_OTHER, 8'd0,   32'h0000_0000, 1'b1, ST_IGNORED},
		'{REQ_PUSH,  8'd8,   32'h1234_5678, 1'b1, ST_BAD_INDEX},
		'{REQ_POP,   8'd255, 32'h0000_0000, 1'b1, ST_BAD_INDEX},
		'{REQ_DUMP,  8'd128, 32'h0000_0000, 1'b1, ST_BAD_INDEX},
		'{REQ_PUSH,  8'd0,   32'h7FFF_FFFF, 1'b1, ST_OK},
		'{REQ_PUSH,  8'd0,   32'h8000_0000, 1'b1, ST_OK},
		'{REQ_PUSH,  8'd0,   32'hFFFF_FFFF, 1'b1, ST_OK},
		'{REQ_PUSH,  8'd7,   32'h0000_0000, 1'b1, ST_OK},
		'{REQ_DUMP,  8'd0,   32'h0000_0000, 1'b0, ST_OK},
		'{REQ_POP,   8'd0,   32'h0000_0000, 1'b1, ST_OK},
		'{REQ_POP,   8'd7,   32'h0000_0000, 1'b1, ST_OK},
		'{REQ_POP,   8'd7,   32'h0000_0000, 1'b1, ST_POP_EMPTY},
		'{REQ_PUSH,  8'd3,   32'hA5A5_5A5A, 1'b1, ST_OK},
		'{REQ_PUSH,  8'd3,   32'h5A5A_A5A5, 1'b1, ST_OK},
		'{REQ_PUSH,  8'd3,   32'h0000_0001, 1'b1, ST_OK},
		'{REQ_DUMP,  8'd3,   32'h0000_0000, 1'b0, ST_OK},
		'{REQ_DUMP,  8'd0,   32'h0000_0000, 1'b0, ST_OK},
		'{REQ_POP,   8'd3,   32'h0000_0000, 1'b0, ST_OK},
		'{REQ_DUMP,  8'd7,   32'h0000_0000, 1'b1, ST_DUMP_EMPTY},
		'{REQ_OTHER, 8'd7,   32'hFFFF_FFFF, 1'b1, ST_IGNORED}
	};

	multi_stack_bank dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.m_axis_tlast  (m_axis_tlast)
	);

	initial begin
		forever #10 clk = ~clk;
	end

	task automatic report_mismatch(input string msg);
		$display("mismatch at %0t: %s", $realtime, msg);
		errors++;
	endtask

	task automatic queue_result(input logic [VAL_W-1:0] value, input logic [STATUS_W-1:0] status,
			input logic last);
		result_t r;
		r.value = value;
		r.status = status;
		r.last = last;
		queued_results.push_back(r);
	endtask

	task automatic clear_stacks();
		for (int i = 0; i < NUM_STACKS; i++)
			stack_top[i] = NIL;
		free_list_head = NIL;
		fresh_nodes = '0;
		pool_full_hits = 0;
	endtask

	// updates the linked stacks and queues the results that one request causes
	task automatic apply_stack_request(input logic [REQ_W-1:0] req, input logic [IDX_W-1:0] idx,
			input logic [VAL_W-1:0] val);
		logic [6:0] node;
		logic [6:0] nxt;
		int         k;
		if (req == REQ_OTHER) begin
			queue_result('0, ST_IGNORED, 1'b1);
			return;
		end
		if (idx >= NUM_STACKS) begin
			queue_result('0, ST_BAD_INDEX, 1'b1);
			return;
		end
		case (req)
			REQ_PUSH: begin
				if (free_list_head != NIL) begin
					node = free_list_head;
					free_list_head = node_next[node];
				end else if (fresh_nodes != NIL) begin
					node = fresh_nodes;
					fresh_nodes = fresh_nodes + 7'd1;
				end else begin
					pool_full_hits++;
					queue_result('0, ST_FULL, 1'b1);
					return;
				end
				node_value[node] = val;
				node_next[node] = stack_top[idx];
				stack_top[idx] = node;
				queue_result('0, ST_OK, 1'b1);
			end
			REQ_POP: begin
				node = stack_top[idx];
				if (node == NIL) begin
					queue_result('0, ST_POP_EMPTY, 1'b1);
					return;
				end
				stack_top[idx] = node_next[node];
				node_next[node] = free_list_head;
				free_list_head = node;
				queue_result('0, ST_OK, 1'b1);
			end
			default: begin
				node = stack_top[idx];
				if (node == NIL) begin
					queue_result('0, ST_DUMP_EMPTY, 1'b1);
					return;
				end
				k = 0;
				while (node != NIL && k < POOL_NODES) begin
					nxt = node_next[node];
					queue_result(node_value[node], ST_OK, (nxt == NIL || k + 1 >= POOL_NODES));
					k++;
					node = nxt;
				end
			end
		endcase
	endtask

	task automatic send_request(input logic [REQ_W-1:0] req, input logic [IDX_W-1:0] idx,
			input logic [VAL_W-1:0] val);
		while ($urandom_range(99) < send_idle) begin
			s_axis_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tuser <= req;
		s_axis_tdata <= {val, idx};
		do @(posedge clk); while (!s_axis_tready);
		apply_stack_request(req, idx, val);
	endtask

	task automatic pick_request(input int mix, output logic [REQ_W-1:0] req,
			output logic [IDX_W-1:0] idx, output logic [VAL_W-1:0] val);
		int r;
		int push_cut;
		int pop_cut;
		int dump_cut;
		int other_cut;
		r = $urandom_range(99);
		case (mix)
			MIX_FILL: begin
				push_cut = 88; pop_cut = 92; dump_cut = 96; other_cut = 98;
			end
			MIX_DRAIN: begin
				push_cut = 20; pop_cut = 65; dump_cut = 85; other_cut = 92;
			end
			default: begin
				push_cut = 40; pop_cut = 60; dump_cut = 75; other_cut = 82;
			end
		endcase
		val = $urandom;
		idx = IDX_W'($urandom_range(NUM_STACKS - 1));
		if (r < push_cut)
			req = REQ_PUSH;
		else if (r < pop_cut)
			req = REQ_POP;
		else if (r < dump_cut)
			req = REQ_DUMP;
		else if (r < other_cut) begin
			req = REQ_OTHER;
			idx = IDX_W'($urandom_range(255));
		end else begin
			req = REQ_W'($urandom_range(2));
			idx = IDX_W'($urandom_range(255, NUM_STACKS));
		end
	endtask

	always @(posedge clk) begin
		m_axis_tready <= ($urandom_range(99) >= recv_idle);
	end

	always @(posedge clk) begin : check_results
		result_t want;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			if (queued_results.size() == 0) begin
				report_mismatch($sformatf("unexpected transfer: value %h status %0d last %0b",
					m_axis_tdata, m_axis_tuser, m_axis_tlast));
			end else begin
				want = queued_results.pop_front();
				if (m_axis_tdata !== want.value)
					report_mismatch($sformatf("value %h, want %h", m_axis_tdata, want.value));
				if (m_axis_tuser !== want.status)
					report_mismatch($sformatf("status %0d, want %0d", m_axis_tuser, want.status));
				if (m_axis_tlast !== want.last)
					report_mismatch($sformatf("last %0b, want %0b", m_axis_tlast, want.last));
			end
		end
	end

	always @(posedge clk) begin
		if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= STALL_LIMIT) begin
			$display("timeout: no transfer for %0d cycles", STALL_LIMIT);
			$display("[multi_stack_bank] ERROR");
			$finish;
		end
	end

	initial begin
		logic [REQ_W-1:0] req;
		logic [IDX_W-1:0] idx;
		logic [VAL_W-1:0] val;
		int               n;
		send_idle = 15;
		recv_idle = 49;
		clear_stacks();
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed_rows[i]) begin
			send_request(directed_rows[i].req, directed_rows[i].idx, directed_rows[i].val);
			if (directed_rows[i].typed)
				queued_results[queued_results.size() - 1] =
					'{value: '0, status: directed_rows[i].status, last: 1'b1};
		end

		for (n = 0; n < 20; n++) begin
			pick_request(MIX_BALANCED, req, idx, val);
			send_request(req, idx, val);
		end

		// mostly pushes, at least 30, until the pool has refused four of them or 200 are sent
		send_idle = 49;
		recv_idle = 15;
		n = 0;
		while ((n < 30 || pool_full_hits < 4) && n < 200) begin
			pick_request(MIX_FILL, req, idx, val);
			send_request(req, idx, val);
			n++;
		end

		send_idle = 0;
		recv_idle = 0;
		for (n = 0; n < 20; n++) begin
			pick_request(MIX_DRAIN, req, idx, val);
			send_request(req, idx, val);
		end
		s_axis_tvalid <= 1'b0;

		while (queued_results.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (errors == 0)
			$display("[multi_stack_bank] OK");
		else
			$display("[multi_stack_bank] ERROR");
		$finish;
	end

endmodule

@@ sim.f @@
rtl/msb_pkg.sv
rtl/msb_ram.sv
rtl/msb_front.sv
rtl/msb_queue.sv
rtl/msb_back.sv
rtl/multi_stack_bank.sv
dv/tb_multi_stack_bank.sv
